@@ hdl/generational_handle_table_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the generational handle table core
// Clocked, reset-qualified property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define GHT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define GHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg
// Shared constants, codes and types of the generational handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

    // Default capacity and fixed field widths
    localparam int TABLE_SLOTS_DEF = 256;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int OBJ_W           = 32;
    localparam int GEN_W           = 32;
    localparam int HSLOT_W         = 32;
    localparam int NEW_SLOT_W      = 8;
    localparam int LIVE_COUNT_W    = 9;

    localparam logic [GEN_W-1:0] GEN_MAX  = {GEN_W{1'b1}};
    localparam logic [GEN_W-1:0] GEN_INIT = GEN_W'(1);

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_LOOKUP = 2'd1;
    localparam mode_t MODE_REMOVE = 2'd2;

    // Status codes
    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_ARG    = 2'd1;
    localparam status_t ST_BAD_HANDLE = 2'd2;
    localparam status_t ST_EXHAUSTED  = 2'd3;

    // Slot contents apart from the free-list link
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             live;
        logic [OBJ_W-1:0] obj;
    } ght_entry_t;

    // Update controls handed from the evaluator to the top level
    typedef struct packed {
        logic wr_en;
        logic head_load;
        logic live_inc;
        logic live_dec;
    } ght_upd_t;

endpackage

`default_nettype wire

@@ hdl/ght_slot_ram.sv @@
// ----------------------------------------------------------------------------
// ght_slot_ram
// Single-port-write, single-port-read synchronous slot memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_slot_ram #(
    parameter int DEPTH = ght_pkg::TABLE_SLOTS_DEF,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the updated slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/ght_slot_eval.sv @@
// ----------------------------------------------------------------------------
// ght_slot_eval
// Decide the outcome of one request from the slot read back from memory and
// build the modified slot, the new free-list head and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_slot_eval #(
    parameter int TABLE_SLOTS = ght_pkg::TABLE_SLOTS_DEF
) (
    input  wire ght_pkg::mode_t                    mode,
    input  wire logic [ght_pkg::OBJ_W-1:0]         obj,
    input  wire logic [ght_pkg::GEN_W-1:0]         hgen,
    input  wire logic                              in_range,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0]    addr,
    input  wire logic [$clog2(TABLE_SLOTS+1)-1:0]  head,
    input  wire logic                              touched,
    input  wire ght_pkg::ght_entry_t               rd_entry,
    input  wire logic [$clog2(TABLE_SLOTS+1)-1:0]  rd_next,
    output ght_pkg::ght_upd_t                      upd,
    output ght_pkg::ght_entry_t                    wr_entry,
    output logic      [$clog2(TABLE_SLOTS+1)-1:0]  wr_next,
    output logic      [$clog2(TABLE_SLOTS+1)-1:0]  new_head,
    output ght_pkg::status_t                       status,
    output logic      [ght_pkg::GEN_W-1:0]         new_gen,
    output logic      [ght_pkg::OBJ_W-1:0]         found
);

    localparam int LW = $clog2(TABLE_SLOTS + 1);

    localparam logic [LW-1:0] LINK_END = LW'(TABLE_SLOTS);

    ght_pkg::ght_entry_t cur;
    logic [LW-1:0]       cur_next;
    logic                handle_ok;
    logic [ght_pkg::GEN_W-1:0] gen_bump;

    // Substitute the reset contents for a slot never handed out
    always_comb
    begin
        if (touched)
        begin
            cur      = rd_entry;
            cur_next = rd_next;
        end
        else
        begin
            cur.gen  = ght_pkg::GEN_INIT;
            cur.live = 1'b0;
            cur.obj  = '0;
            cur_next = LW'(addr) + LW'(1);
        end
    end

    // Check the handle and advance the generation, skipping zero on wrap
    assign handle_ok = in_range && cur.live && (cur.gen == hgen);
    assign gen_bump  = (cur.gen == ght_pkg::GEN_MAX) ? ght_pkg::GEN_INIT
                                                     : cur.gen + ght_pkg::GEN_W'(1);

    // Decide the request
    always_comb
    begin
        upd           = '0;
        wr_entry      = cur;
        wr_next       = cur_next;
        new_head      = head;
        status        = ght_pkg::ST_OK;
        new_gen       = '0;
        found         = '0;
        unique case (mode)
            ght_pkg::MODE_INSERT:
            begin
                if (obj == '0)
                begin
                    status = ght_pkg::ST_BAD_ARG;
                end
                else if (head >= LINK_END)
                begin
                    status = ght_pkg::ST_EXHAUSTED;
                end
                else
                begin
                    upd.wr_en      = 1'b1;
                    upd.head_load  = 1'b1;
                    upd.live_inc   = 1'b1;
                    wr_entry.live  = 1'b1;
                    wr_entry.obj   = obj;
                    wr_next        = LINK_END;
                    new_head       = cur_next;
                    new_gen        = cur.gen;
                end
            end
            ght_pkg::MODE_LOOKUP:
            begin
                if (handle_ok)
                begin
                    found = cur.obj;
                end
                else
                begin
                    status = ght_pkg::ST_BAD_HANDLE;
                end
            end
            ght_pkg::MODE_REMOVE:
            begin
                if (handle_ok)
                begin
                    upd.wr_en      = 1'b1;
                    upd.head_load  = 1'b1;
                    upd.live_dec   = 1'b1;
                    wr_entry.gen   = gen_bump;
                    wr_entry.live  = 1'b0;
                    wr_entry.obj   = '0;
                    wr_next        = head;
                    new_head       = LW'(addr);
                end
                else
                begin
                    status = ght_pkg::ST_BAD_HANDLE;
                end
            end
            default:
            begin
                status = ght_pkg::ST_BAD_ARG;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/generational_handle_table_core.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table_core
// Fixed-capacity slot map issuing (slot, generation) handles: insert, lookup
// and remove against one synchronous slot memory, read-modify-write.
//
//   channel  | handshake                 | fields
//   ---------+---------------------------+--------------------------------------
//   request  | start, busy               | mode, object_value, handle_slot,
//            |                           | handle_generation
//   result   | done (one-cycle strobe)   | status, new_slot, new_generation,
//            |                           | found_object, live_count
//
// Each request reads the slot memory in the accept cycle, then evaluates and
// writes back in the next; busy covers that evaluation cycle, so no new request
// is taken until the previous one has left evaluation.
// The result strobe is registered from the evaluation stage and cannot be stalled.
// After reset the table is usable at once: slots at or above the fill count
// read as their reset contents, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_core #(
    parameter int TABLE_SLOTS = ght_pkg::TABLE_SLOTS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [ght_pkg::MODE_W-1:0]           mode,
    input  wire logic [ght_pkg::OBJ_W-1:0]            object_value,
    input  wire logic [ght_pkg::HSLOT_W-1:0]          handle_slot,
    input  wire logic [ght_pkg::GEN_W-1:0]            handle_generation,
    output logic                                      done,
    output logic      [ght_pkg::STATUS_W-1:0]         status,
    output logic      [ght_pkg::NEW_SLOT_W-1:0]       new_slot,
    output logic      [ght_pkg::GEN_W-1:0]            new_generation,
    output logic      [ght_pkg::OBJ_W-1:0]            found_object,
    output logic      [ght_pkg::LIVE_COUNT_W-1:0]     live_count
);

    localparam int IW     = $clog2(TABLE_SLOTS);
    localparam int LW     = $clog2(TABLE_SLOTS + 1);
    localparam int ENT_W  = $bits(ght_pkg::ght_entry_t);
    localparam int WORD_W = ENT_W + LW;

    // Request stage
    logic                      s1_valid_reg;
    ght_pkg::mode_t            s1_mode_reg;
    logic [ght_pkg::OBJ_W-1:0] s1_obj_reg;
    logic [ght_pkg::GEN_W-1:0] s1_hgen_reg;
    logic [IW-1:0]             s1_addr_reg;
    logic                      s1_in_range_reg;

    // Table bookkeeping
    logic [LW-1:0]             head_reg;
    logic [LW-1:0]             live_reg;
    logic [LW-1:0]             fill_reg;

    // Result registers
    logic                      done_reg;
    ght_pkg::status_t          status_reg;
    logic [ght_pkg::NEW_SLOT_W-1:0]   new_slot_reg;
    logic [ght_pkg::GEN_W-1:0]        new_gen_reg;
    logic [ght_pkg::OBJ_W-1:0]        found_reg;
    logic [ght_pkg::LIVE_COUNT_W-1:0] live_count_reg;

    logic                      accept;
    logic [IW-1:0]             rd_addr;
    logic [WORD_W-1:0]         rd_word;
    logic [WORD_W-1:0]         wr_word;
    logic                      touched;
    logic [LW-1:0]             live_next;

    ght_pkg::ght_upd_t         upd;
    ght_pkg::ght_entry_t       wr_entry;
    logic [LW-1:0]             wr_next;
    logic [LW-1:0]             new_head;
    ght_pkg::status_t          ev_status;
    logic [ght_pkg::GEN_W-1:0] ev_gen;
    logic [ght_pkg::OBJ_W-1:0] ev_found;

    // Accept a request and pick the slot to read
    assign accept  = start && !s1_valid_reg;
    assign rd_addr = (ght_pkg::mode_t'(mode) == ght_pkg::MODE_INSERT) ? head_reg[IW-1:0]
                                                                      : handle_slot[IW-1:0];

    // Slots below the fill count have been written at least once
    assign touched = LW'(s1_addr_reg) < fill_reg;
    assign wr_word = {wr_entry, wr_next};

    ght_slot_ram #(
        .DEPTH (TABLE_SLOTS),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s1_valid_reg && upd.wr_en),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    ght_slot_eval #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_eval (
        .mode     (s1_mode_reg),
        .obj      (s1_obj_reg),
        .hgen     (s1_hgen_reg),
        .in_range (s1_in_range_reg),
        .addr     (s1_addr_reg),
        .head     (head_reg),
        .touched  (touched),
        .rd_entry (ght_pkg::ght_entry_t'(rd_word[WORD_W-1:LW])),
        .rd_next  (rd_word[LW-1:0]),
        .upd      (upd),
        .wr_entry (wr_entry),
        .wr_next  (wr_next),
        .new_head (new_head),
        .status   (ev_status),
        .new_gen  (ev_gen),
        .found    (ev_found)
    );

    // Adjust the live count, never below zero
    always_comb
    begin
        live_next = live_reg;
        priority if (upd.live_inc)
        begin
            live_next = live_reg + LW'(1);
        end
        else if (upd.live_dec && (live_reg != '0))
        begin
            live_next = live_reg - LW'(1);
        end
        else
        begin
            live_next = live_reg;
        end
    end

    // Hold the request for its evaluation cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg     <= ght_pkg::mode_t'(mode);
            s1_obj_reg      <= object_value;
            s1_hgen_reg     <= handle_generation;
            s1_addr_reg     <= rd_addr;
            s1_in_range_reg <= handle_slot < ght_pkg::HSLOT_W'(TABLE_SLOTS);
        end
    end

    // Advance control state and bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            head_reg     <= '0;
            live_reg     <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            done_reg     <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                live_reg <= live_next;
                if (upd.head_load)
                begin
                    head_reg <= new_head;
                end
                if (upd.live_inc && !touched)
                begin
                    fill_reg <= fill_reg + LW'(1);
                end
            end
        end
    end

    // Register the result fields
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            status_reg     <= ev_status;
            new_slot_reg   <= upd.live_inc ? ght_pkg::NEW_SLOT_W'(s1_addr_reg) : '0;
            new_gen_reg    <= ev_gen;
            found_reg      <= ev_found;
            live_count_reg <= ght_pkg::LIVE_COUNT_W'(live_next);
        end
    end

    assign busy           = s1_valid_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign new_slot       = new_slot_reg;
    assign new_generation = new_gen_reg;
    assign found_object   = found_reg;
    assign live_count     = live_count_reg;

endmodule

`default_nettype wire

@@ hdl/ght_checker.sv @@
// ----------------------------------------------------------------------------
// ght_checker
// Port-level checks on request timing and result consistency, bound to the
// generational handle table core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_core_macros.svh"

module ght_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic                                 done,
    input wire logic [ght_pkg::STATUS_W-1:0]         status,
    input wire logic [ght_pkg::NEW_SLOT_W-1:0]       new_slot,
    input wire logic [ght_pkg::GEN_W-1:0]            new_generation,
    input wire logic [ght_pkg::OBJ_W-1:0]            found_object
);

    // An accepted request occupies the block for its evaluation cycle
    `GHT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "request accepted but block not busy in the next cycle")

    // Evaluation ends in exactly one result strobe
    `GHT_ASSERT_NEXT(a_busy_done, clk, rst_n, busy, done && !busy, "evaluation cycle not followed by a result")

    // A failed request carries no handle and no object
    `GHT_ASSERT_SAME(a_fail_zero, clk, rst_n, done && (status != ght_pkg::ST_OK), (new_slot == '0) && (new_generation == '0) && (found_object == '0), "failed request returned nonzero fields")

    // An issued handle and a found object never appear together
    `GHT_ASSERT_SAME(a_excl, clk, rst_n, done, (new_generation == '0) || (found_object == '0), "insert and lookup results mixed")

endmodule

bind generational_handle_table_core ght_checker u_ght_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .status         (status),
    .new_slot       (new_slot),
    .new_generation (new_generation),
    .found_object   (found_object)
);

`default_nettype wire
